### rtl/rtsw_pkg.sv
// Shared types, widths and constants of the tristate remote switch transmitter.
// Holds the telegram builder function; depends on nothing.
`default_nettype none

package rtsw_pkg;

   localparam int PULSE_W  = 16;
   localparam int REPEAT_W = 8;
   localparam int CODE_W   = 5;
   localparam int TEL_W    = 24;
   localparam int PAIR_W   = 6;
   localparam int UNIT_W   = 5;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [PAIR_W-1:0] PAIR_COUNT     = PAIR_W'(TEL_W);
   localparam logic [UNIT_W-1:0] SYNC_LOW_UNITS = UNIT_W'(31);
   localparam logic [UNIT_W-1:0] SHORT_UNITS    = UNIT_W'(1);
   localparam logic [UNIT_W-1:0] LONG_UNITS     = UNIT_W'(3);

   localparam logic [PULSE_W-1:0]  PULSE_RESET  = PULSE_W'(350);
   localparam logic [REPEAT_W-1:0] REPEAT_RESET = REPEAT_W'(10);

   // register index, taken from paddr[2]
   localparam logic REG_PULSE_LENGTH = 1'b0;
   localparam logic REG_REPEAT_COUNT = 1'b1;

   typedef struct packed {
      logic [PULSE_W-1:0]  pulse_length;
      logic [REPEAT_W-1:0] repeat_count;
   } cfg_type;

   typedef struct packed {
      logic              start_req;
      logic [CODE_W-1:0] group_code;
      logic [CODE_W-1:0] device_code;
      logic              switch_on;
   } req_item_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic done_res;
   } rsp_item_type;

   // One bit per pulse pair, pair 0 in the top bit: 0 is (1,3), 1 is (3,1).
   // Symbol F = pairs 0,1; symbol 0 = pairs 0,0. Code bit 0 sends F.
   function automatic logic [TEL_W-1:0] build_telegram(
      input logic [CODE_W-1:0] group,
      input logic [CODE_W-1:0] device,
      input logic              on);
      logic [TEL_W-1:0] tel;
      tel = '0;
      for (int i = 0; i < CODE_W; i++) begin
         tel[TEL_W-1-2*i -: 2]          = {1'b0, ~group[CODE_W-1-i]};
         tel[TEL_W-1-2*(CODE_W+i) -: 2] = {1'b0, ~device[CODE_W-1-i]};
      end
      tel[3:2] = {1'b0, ~on};
      tel[1:0] = {1'b0, on};
      return tel;
   endfunction

endpackage

`default_nettype wire

### rtl/rtsw_csr.sv
// Configuration registers of the transmitter behind an APB-style port.
// Depends on rtsw_pkg.
`default_nettype none

module rtsw_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [rtsw_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [rtsw_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [rtsw_pkg::DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output rtsw_pkg::cfg_type              cfg
);
   import rtsw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_PULSE_LENGTH: cfg_in.pulse_length = csr_pwdata[PULSE_W-1:0];
            REG_REPEAT_COUNT: cfg_in.repeat_count = csr_pwdata[REPEAT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_length <= PULSE_RESET;
         cfg_ff.repeat_count <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PULSE_LENGTH: csr_prdata = DATA_W'(cfg_ff.pulse_length);
         REG_REPEAT_COUNT: csr_prdata = DATA_W'(cfg_ff.repeat_count);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/rtsw_seq.sv
// Telegram sequencer: pair, phase, unit and tick counters advanced once per tick item.
// Depends on rtsw_pkg.
`default_nettype none

module rtsw_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_fire,
   input  rtsw_pkg::req_item_type      item,
   input  rtsw_pkg::cfg_type           cfg,
   output rtsw_pkg::rsp_item_type      res
);
   import rtsw_pkg::*;

   logic [TEL_W-1:0]    tel_ff, tel_in, tel_eff;
   logic [PAIR_W-1:0]   pair_ff, pair_in, pair_eff;
   logic                high_ff, high_in, high_eff;
   logic [UNIT_W-1:0]   unit_ff, unit_in, unit_eff, unit_inc, phase_len;
   logic [PULSE_W-1:0]  tick_ff, tick_in, tick_eff, tick_inc, plen;
   logic [REPEAT_W-1:0] reps_ff, reps_in, reps_eff, reps_dec;
   logic                active_ff, active_in, active_eff;
   logic                start_take, long_high;

   assign start_take = !active_ff && item.start_req;
   assign plen       = (cfg.pulse_length == '0) ? PULSE_W'(1) : cfg.pulse_length;

   // Load a fresh telegram on a taken start
   always_comb begin
      tel_eff    = tel_ff;
      pair_eff   = pair_ff;
      high_eff   = high_ff;
      unit_eff   = unit_ff;
      tick_eff   = tick_ff;
      reps_eff   = reps_ff;
      active_eff = active_ff;
      if (start_take) begin
         tel_eff    = build_telegram(item.group_code, item.device_code, item.switch_on);
         pair_eff   = '0;
         high_eff   = 1'b1;
         unit_eff   = '0;
         tick_eff   = '0;
         reps_eff   = (cfg.repeat_count == '0) ? REPEAT_W'(1) : cfg.repeat_count;
         active_eff = 1'b1;
      end
   end

   assign long_high = tel_eff[(UNIT_W)'(PAIR_COUNT - PAIR_W'(1) - pair_eff)];
   assign tick_inc  = tick_eff + PULSE_W'(1);
   assign unit_inc  = unit_eff + UNIT_W'(1);
   assign reps_dec  = reps_eff - REPEAT_W'(1);

   always_comb begin
      if (pair_eff >= PAIR_COUNT) begin
         phase_len = high_eff ? SHORT_UNITS : SYNC_LOW_UNITS;
      end else if (high_eff) begin
         phase_len = long_high ? LONG_UNITS : SHORT_UNITS;
      end else begin
         phase_len = long_high ? SHORT_UNITS : LONG_UNITS;
      end
   end

   always_comb begin
      tel_in    = tel_eff;
      pair_in   = pair_eff;
      high_in   = high_eff;
      unit_in   = unit_eff;
      tick_in   = tick_eff;
      reps_in   = reps_eff;
      active_in = active_eff;
      res       = '0;
      if (active_eff) begin
         res.pin_level = high_eff;
         res.busy_res  = 1'b1;
         tick_in       = tick_inc;
         if (tick_inc >= plen || tick_inc == '0) begin
            tick_in = '0;
            unit_in = unit_inc;
            if (unit_inc >= phase_len || unit_inc == '0) begin
               unit_in = '0;
               if (high_eff) begin
                  high_in = 1'b0;
               end else begin
                  high_in = 1'b1;
                  if (pair_eff >= PAIR_COUNT) begin
                     pair_in = '0;
                     reps_in = reps_dec;
                     if (reps_dec == '0) begin
                        active_in    = 1'b0;
                        high_in      = 1'b0;
                        res.done_res = 1'b1;
                     end
                  end else begin
                     pair_in = pair_eff + PAIR_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         tel_ff <= tel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff   <= '0;
         high_ff   <= 1'b0;
         unit_ff   <= '0;
         tick_ff   <= '0;
         reps_ff   <= '0;
         active_ff <= 1'b0;
      end else if (item_fire) begin
         pair_ff   <= pair_in;
         high_ff   <= high_in;
         unit_ff   <= unit_in;
         tick_ff   <= tick_in;
         reps_ff   <= reps_in;
         active_ff <= active_in;
      end
   end

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      item_fire && res.done_res |=> !active_ff)
      else $error("transmission still active after done");

   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> pair_ff <= PAIR_COUNT)
      else $error("pair index beyond sync pair");

   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !high_ff)
      else $error("high phase while idle");

   a_repeats_live: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> reps_ff != '0)
      else $error("active with no repeats left");

endmodule

`default_nettype wire

### rtl/tristate_remote_switch_transmitter_core.sv
// Top level of the tristate remote switch transmitter: input and result registers,
// configuration block and telegram sequencer. Depends on rtsw_pkg, rtsw_csr, rtsw_seq.
`default_nettype none

// Usage
//   req_* carries one time tick per item (one microsecond by convention). A tick with
//   req_start_req high while idle latches group code, device code and on/off into a
//   12-symbol tristate telegram and starts sending; starts while busy are dropped.
//   rsp_* returns exactly one item per tick: the data pin level for that tick,
//   busy, and done on the final tick of the last repeat.
//   csr_* is an APB-style port: pulse_length at byte 0, repeat_count at byte 4.
//   Write configuration only while idle.
// Throughput and flow
//   One tick item per cycle sustained while rsp_ready stays high. An item is taken
//   into the input register; when the result register is free or being drained,
//   the sequencer advances its counters and fills the result register from it.
// Stall
//   When rsp_ready is low the result register holds its item, the input register
//   holds the next one once taken, and req_ready then drops; no tick is lost or repeated.
// Reset
//   Synchronous, active high: both registers empty, sequencer idle, pulse_length 350,
//   repeat_count 10.
module tristate_remote_switch_transmitter_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // tick input channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_start_req,
   input  wire logic [rtsw_pkg::CODE_W-1:0] req_group_code,
   input  wire logic [rtsw_pkg::CODE_W-1:0] req_device_code,
   input  wire logic                        req_switch_on,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_pin_level,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rtsw_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [rtsw_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [rtsw_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import rtsw_pkg::*;

   cfg_type      cfg;
   req_item_type req_item_ff, req_item_in;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance, req_take, rsp_take;

   rtsw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Advance the held item into the sequencer when the result register frees up
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rtsw_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (req_item_ff),
      .cfg       (cfg),
      .res       (rsp_item_in)
   );

   always_comb begin
      req_item_in.start_req   = req_start_req;
      req_item_in.group_code  = req_group_code;
      req_item_in.device_code = req_device_code;
      req_item_in.switch_on   = req_switch_on;
   end

   // Hold the input item until the sequencer consumes it
   always_comb begin
      priority if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   // Result register fills on advance, drains on take
   always_comb begin
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_item_ff.pin_level;
   assign rsp_busy_res  = rsp_item_ff.busy_res;
   assign rsp_done_res  = rsp_item_ff.done_res;

endmodule

`default_nettype wire
